// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("receiver assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("receiver assertion failed");

`endif

// ===== sv/idfsr_pkg.sv =====
// Types and constants of the framed, sum-checked byte receiver.
`default_nettype none

package idfsr_pkg;

   localparam int BYTE_W            = 8;
   localparam int NUM_IDS           = 6;
   localparam int CSR_IDX_W         = 3;
   localparam int SUM_W             = 16;
   localparam int STATUS_W          = 3;
   localparam int PAYLOAD_W         = 64;
   localparam int PAYLOAD_BYTES_DEF = 8;

   // Result word: status, frame id, payload, zero fill to whole bytes
   localparam int RSP_FIELD_W = STATUS_W + BYTE_W + PAYLOAD_W;
   localparam int RSP_W       = ((RSP_FIELD_W + BYTE_W - 1) / BYTE_W) * BYTE_W;
   localparam int RSP_PAD_W   = RSP_W - RSP_FIELD_W;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_COMPL = 2'd1,
      PH_DATA  = 2'd2,
      PH_CSUM  = 2'd3
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_BUSY     = 3'd0,
      ST_GOOD     = 3'd1,
      ST_BADID    = 3'd2,
      ST_BADCOMPL = 3'd3,
      ST_BADSUM   = 3'd4
   } status_type;

   // One register write from the csr channel
   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      logic [BYTE_W-1:0]    data;
   } csr_wr_type;

endpackage

`default_nettype wire

// ===== sv/idfsr_id_table.sv =====
// Accepted frame ID registers and the frame-start ID match.
`default_nettype none

module idfsr_id_table (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire idfsr_pkg::csr_wr_type      csr_wr,
   input  wire logic [idfsr_pkg::BYTE_W-1:0] probe,
   output logic                            hit
);

   logic [idfsr_pkg::BYTE_W-1:0] ids_ff [idfsr_pkg::NUM_IDS];

   // Register writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < idfsr_pkg::NUM_IDS; i++) begin
            ids_ff[i] <= '0;
         end
      end else if (csr_wr.valid) begin
         for (int i = 0; i < idfsr_pkg::NUM_IDS; i++) begin
            if (csr_wr.index == idfsr_pkg::CSR_IDX_W'(i)) begin
               ids_ff[i] <= csr_wr.data;
            end
         end
      end
   end

   // Compare against all six IDs at once
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < idfsr_pkg::NUM_IDS; i++) begin
         if (ids_ff[i] == probe) begin
            hit = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/id_framed_sum_checked_receiver.sv =====
// Top level of the ID-framed, sum-checked byte receiver.
// Each accepted req word yields its rsp word in the next cycle.
// Throughput: one byte per cycle; the output register is refilled in the
// cycle it is taken, so req_tready only drops while a result waits.
// Reset clears the phase, counters, running sum, ID registers and the
// committed frame to zero; the output register comes up empty.
`default_nettype none

module id_framed_sum_checked_receiver #(
   parameter int PAYLOAD_BYTES = idfsr_pkg::PAYLOAD_BYTES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: [7:0] rx_byte
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [idfsr_pkg::BYTE_W-1:0]        req_tdata,
   // rsp_tdata: [2:0] status, [10:3] frame_id, [74:11] frame_payload, rest zero
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [idfsr_pkg::RSP_W-1:0]              rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [idfsr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [idfsr_pkg::BYTE_W-1:0]        csr_data
);

   localparam int CntW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int BW   = idfsr_pkg::BYTE_W;

   idfsr_pkg::csr_wr_type csr_wr;
   logic                  id_hit;
   logic                  accept;
   logic                  commit;
   logic                  shift_en;

   idfsr_pkg::phase_type  phase_ff, phase_in;
   idfsr_pkg::status_type status_ff, status_in;
   logic [BW-1:0]         pend_id_ff, pend_id_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic [idfsr_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [BW-1:0]         csum_hi_ff, csum_hi_in;
   logic                  hi_seen_ff, hi_seen_in;
   logic                  rsp_valid_ff;
   logic [BW-1:0]         com_id_ff;
   logic [idfsr_pkg::PAYLOAD_W-1:0] com_pay_ff;
   logic [BW-1:0]         pend_ff [PAYLOAD_BYTES];

   // Config port never stalls
   assign csr_ready     = 1'b1;
   assign csr_wr.valid  = csr_valid;
   assign csr_wr.index  = csr_index;
   assign csr_wr.data   = csr_data;

   idfsr_id_table u_ids (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .probe  (req_tdata),
      .hit    (id_hit)
   );

   // Take a new word whenever the output register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Deframer next state
   always_comb begin
      phase_in   = phase_ff;
      status_in  = idfsr_pkg::ST_BUSY;
      pend_id_in = pend_id_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      csum_hi_in = csum_hi_ff;
      hi_seen_in = hi_seen_ff;
      commit     = 1'b0;
      shift_en   = 1'b0;
      unique case (phase_ff)
         idfsr_pkg::PH_HUNT: begin
            if (id_hit) begin
               pend_id_in = req_tdata;
               phase_in   = idfsr_pkg::PH_COMPL;
            end else begin
               status_in = idfsr_pkg::ST_BADID;
            end
         end
         idfsr_pkg::PH_COMPL: begin
            if (~req_tdata == pend_id_ff) begin
               phase_in = idfsr_pkg::PH_DATA;
               cnt_in   = '0;
               sum_in   = '0;
            end else begin
               status_in = idfsr_pkg::ST_BADCOMPL;
               phase_in  = idfsr_pkg::PH_HUNT;
            end
         end
         idfsr_pkg::PH_DATA: begin
            shift_en = 1'b1;
            sum_in   = sum_ff + idfsr_pkg::SUM_W'(req_tdata);
            if (cnt_ff == CntW'(PAYLOAD_BYTES - 1)) begin
               phase_in   = idfsr_pkg::PH_CSUM;
               cnt_in     = '0;
               hi_seen_in = 1'b0;
            end else begin
               cnt_in = cnt_ff + CntW'(1);
            end
         end
         idfsr_pkg::PH_CSUM: begin
            if (!hi_seen_ff) begin
               csum_hi_in = req_tdata;
               hi_seen_in = 1'b1;
            end else begin
               if ({csum_hi_ff, req_tdata} == sum_ff) begin
                  commit    = 1'b1;
                  status_in = idfsr_pkg::ST_GOOD;
               end else begin
                  status_in = idfsr_pkg::ST_BADSUM;
               end
               hi_seen_in = 1'b0;
               phase_in   = idfsr_pkg::PH_HUNT;
            end
         end
         default: begin
            phase_in = idfsr_pkg::PH_HUNT;
         end
      endcase
   end

   // Deframer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= idfsr_pkg::PH_HUNT;
         pend_id_ff <= '0;
         cnt_ff     <= '0;
         sum_ff     <= '0;
         hi_seen_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pend_id_ff <= pend_id_in;
         cnt_ff     <= cnt_in;
         sum_ff     <= sum_in;
         hi_seen_ff <= hi_seen_in;
      end
   end

   // Checksum high byte holds no reset value
   always_ff @(posedge clock) begin
      if (accept) begin
         csum_hi_ff <= csum_hi_in;
      end
   end

   // Payload shift line: oldest byte ends up in entry zero
   always_ff @(posedge clock) begin
      if (accept && shift_en) begin
         for (int k = 0; k < PAYLOAD_BYTES - 1; k++) begin
            pend_ff[k] <= pend_ff[k+1];
         end
         pend_ff[PAYLOAD_BYTES-1] <= req_tdata;
      end
   end

   // Committed frame, copied on a good checksum
   always_ff @(posedge clock) begin
      if (reset) begin
         com_id_ff  <= '0;
         com_pay_ff <= '0;
      end else if (accept && commit) begin
         com_id_ff <= pend_id_ff;
         for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            com_pay_ff[k*BW +: BW] <= pend_ff[k];
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{idfsr_pkg::RSP_PAD_W{1'b0}}, com_pay_ff, com_id_ff, status_ff};

endmodule

`default_nettype wire

// ===== sv/idfsr_checker.sv =====
// Port-level checker for the receiver, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module idfsr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [idfsr_pkg::RSP_W-1:0]   rsp_tdata
);

   // A stalled result holds its word
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Every accepted byte shows up as a result on the next cycle
   `ASSERT_NEXT(a_rsp_follows, clock, reset, req_tvalid && req_tready, rsp_tvalid)

   // No new byte is taken while a result is stuck
   `ASSERT_IMPL(a_no_overrun, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

   // Fill bits above the fields stay zero
   `ASSERT_IMPL(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[idfsr_pkg::RSP_W-1:idfsr_pkg::RSP_FIELD_W] == '0)

endmodule

bind id_framed_sum_checked_receiver idfsr_checker u_idfsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/id_framed_sum_checked_receiver_test.sv =====
// Testbench: checks byte deframing, ID matching, checksum and committed frame of the receiver.
`timescale 1ns / 100ps

module id_framed_sum_checked_receiver_test;
   import idfsr_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int MAX_REPORTS     = 10;
   localparam int SETTLE_CYCLES   = 4;

   // Which way a sent frame is spoiled
   typedef enum {
      FRAME_CLEAN,
      FRAME_BAD_COMPL,
      FRAME_BAD_SUM,
      FRAME_CUT
   } frame_flaw_type;

   // What one rsp word should carry
   typedef struct {
      status_type        status;
      logic [BYTE_W-1:0] frame_id;
      logic [63:0]       payload;
   } frame_report_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [BYTE_W-1:0]    csr_data   = '0;

   // Deframer state as seen by the testbench
   logic [BYTE_W-1:0] accepted_ids [NUM_IDS] = '{default: '0};
   phase_type         rx_phase    = PH_HUNT;
   logic [BYTE_W-1:0] rx_id       = '0;
   logic [3:0]        rx_count    = '0;
   logic [BYTE_W-1:0] rx_payload [8];
   logic [SUM_W-1:0]  rx_sum      = '0;
   logic [BYTE_W-1:0] rx_sum_high;
   logic [BYTE_W-1:0] last_good_id = '0;
   logic [63:0]       last_good_payload = '0;

   frame_report_type frame_reports [$];
   int            bytes_sent    = 0;
   int            words_seen    = 0;
   int            mismatches    = 0;
   int            cycles        = 0;
   bit            steady_flow   = 1'b0;
   bit            stall_request = 1'b0;
   bit            hold_rsp      = 1'b0;

   id_framed_sum_checked_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] rx_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [2:0] status, [10:3] frame_id, [74:11] payload, rest zero
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles,
                  frame_reports.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Advance the deframer by one byte and return the word it should produce
   function automatic frame_report_type deframe_byte(input logic [BYTE_W-1:0] b);
      frame_report_type r;
      bit            listed;
      int            i;
      r.status = ST_BUSY;
      case (rx_phase)
         PH_HUNT: begin
            listed = 1'b0;
            for (i = 0; i < NUM_IDS; i++)
               if (accepted_ids[i] == b) listed = 1'b1;
            if (listed) begin
               rx_id    = b;
               rx_phase = PH_COMPL;
            end else begin
               r.status = ST_BADID;
            end
         end
         PH_COMPL: begin
            if ((~b) == rx_id) begin
               rx_phase = PH_DATA;
               rx_count = '0;
               rx_sum   = '0;
            end else begin
               r.status = ST_BADCOMPL;
               rx_phase = PH_HUNT;
            end
         end
         PH_DATA: begin
            rx_payload[rx_count[2:0]] = b;
            rx_sum   = rx_sum + SUM_W'(b);
            rx_count = rx_count + 4'd1;
            if (rx_count >= 4'(PAYLOAD_BYTES_DEF)) begin
               rx_phase = PH_CSUM;
               rx_count = '0;
            end
         end
         default: begin
            if (rx_count == 4'd0) begin
               rx_sum_high = b;
               rx_count    = 4'd1;
            end else begin
               if ({rx_sum_high, b} == rx_sum) begin
                  // only the bytes this frame wrote are copied
                  last_good_id = rx_id;
                  for (i = 0; i < PAYLOAD_BYTES_DEF && i < 8; i++)
                     last_good_payload[8*i +: 8] = rx_payload[i];
                  r.status = ST_GOOD;
               end else begin
                  r.status = ST_BADSUM;
               end
               rx_count = '0;
               rx_phase = PH_HUNT;
            end
         end
      endcase
      r.frame_id = last_good_id;
      r.payload  = last_good_payload;
      return r;
   endfunction

   // Offer one byte, with random gaps unless steady_flow is set, and log its expected word once taken
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      frame_reports.push_back(deframe_byte(b));
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [63:0] body,
                             input frame_flaw_type flaw);
      logic [SUM_W-1:0] sum;
      int               cut;
      int               i;
      sum = '0;
      for (i = 0; i < PAYLOAD_BYTES_DEF; i++)
         sum = sum + SUM_W'(body[8*i +: 8]);
      send_byte(id);
      if (flaw == FRAME_BAD_COMPL) begin
         send_byte((~id) ^ 8'($urandom_range(1, 255)));
         return;
      end
      send_byte(~id);
      cut = (flaw == FRAME_CUT) ? $urandom_range(PAYLOAD_BYTES_DEF - 1) : PAYLOAD_BYTES_DEF;
      for (i = 0; i < cut; i++)
         send_byte(body[8*i +: 8]);
      if (flaw == FRAME_CUT)
         return;
      if (flaw == FRAME_BAD_SUM)
         sum = sum ^ (16'd1 << $urandom_range(15));
      send_byte(sum[15:8]);
      send_byte(sum[7:0]);
   endtask

   // Mostly well-formed frames with random content, the rest spoiled frames and noise
   task automatic send_traffic(input int n_bytes);
      int               start;
      int               pick;
      int               k;
      logic [63:0]      body;
      logic [BYTE_W-1:0] id;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         pick = $urandom_range(99);
         k    = $urandom_range(9);
         body = (k == 0) ? '0 : (k == 1) ? '1 : {$urandom, $urandom};
         id   = accepted_ids[$urandom_range(NUM_IDS - 1)];
         if (pick < 60)
            send_frame(id, body, FRAME_CLEAN);
         else if (pick < 70)
            send_frame(id, body, FRAME_BAD_SUM);
         else if (pick < 78)
            send_frame(id, body, FRAME_BAD_COMPL);
         else if (pick < 86)
            send_frame(id, body, FRAME_CUT);
         else
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
   endtask

   // Stop offering and wait until every expected word is back
   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (frame_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_accepted_id(input int idx, input logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      accepted_ids[idx] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // id i of the set sits in bits 8i+7:8i
   task automatic load_id_set(input logic [8*NUM_IDS-1:0] id_set);
      int i;
      quiesce();
      for (i = 0; i < NUM_IDS; i++)
         write_accepted_id(i, id_set[8*i +: 8]);
   endtask

   // Reset ID registers accept ID 0; an all-ones payload and a rejected ID
   task automatic test_reset_ids();
      send_frame(8'h00, '1, FRAME_CLEAN);
      send_byte(8'hFF);
   endtask

   // A non-complement byte that is itself a valid ID must not start a frame
   task automatic test_bad_complement();
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   // Bad checksum keeps the earlier committed frame
   task automatic test_bad_checksum();
      send_frame(8'h00, '0, FRAME_BAD_SUM);
   endtask

   task automatic test_extreme_ids();
      load_id_set({8'hFE, 8'h7F, 8'h80, 8'h01, 8'hFF, 8'h00});
      send_traffic(300);
   endtask

   task automatic test_duplicate_ids();
      load_id_set({8'hC3, 8'hA5, 8'h3C, 8'h3C, 8'hA5, 8'hA5});
      send_traffic(250);
   endtask

   // Back-to-back bytes with the receiver always ready
   task automatic test_steady_stream();
      load_id_set({$urandom, 16'($urandom)});
      steady_flow = 1'b1;
      send_traffic(250);
      quiesce();
      steady_flow = 1'b0;
   endtask

   // Receiver holds off long enough for the block to stall its input
   task automatic test_output_stall();
      quiesce();
      stall_request = 1'b1;
      send_traffic(60);
   endtask

   task automatic test_random_ids();
      load_id_set({$urandom, 16'($urandom)});
      send_traffic(250);
   endtask

   // Long receiver hold-off, counted here
   initial begin : rsp_hold_off
      wait (stall_request);
      hold_rsp = 1'b1;
      repeat (RSP_HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // Receiver readiness
   always @(negedge clock) begin
      if (hold_rsp)
         rsp_tready <= 1'b0;
      else if (steady_flow)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(99) >= 11);
   end

   // Compare each taken word with the oldest expectation
   always @(posedge clock) begin : rsp_check
      frame_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (frame_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("word %0d arrived with nothing expected: %h", words_seen, rsp_tdata);
         end else begin
            want = frame_reports.pop_front();
            if (rsp_tdata[STATUS_W-1:0] !== want.status ||
                rsp_tdata[STATUS_W +: BYTE_W] !== want.frame_id ||
                rsp_tdata[STATUS_W + BYTE_W +: PAYLOAD_W] !== want.payload ||
                rsp_tdata[RSP_W-1 -: RSP_PAD_W] !== '0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("word %0d: status %0d/%0d id %h/%h payload %h/%h fill %h",
                           words_seen, want.status, rsp_tdata[STATUS_W-1:0],
                           want.frame_id, rsp_tdata[STATUS_W +: BYTE_W],
                           want.payload, rsp_tdata[STATUS_W + BYTE_W +: PAYLOAD_W],
                           rsp_tdata[RSP_W-1 -: RSP_PAD_W]);
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_ids();
      test_bad_complement();
      test_bad_checksum();
      test_extreme_ids();
      test_duplicate_ids();
      test_steady_stream();
      test_output_stall();
      test_random_ids();
      quiesce();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/idfsr_pkg.sv
sv/idfsr_id_table.sv
sv/id_framed_sum_checked_receiver.sv
sv/idfsr_checker.sv
tb/id_framed_sum_checked_receiver_test.sv
